// ----- rtl/egw_pkg.sv -----
package egw_pkg;

    localparam int DEF_MAX_WAITERS = 16;
    localparam int DEF_FLAG_BITS   = 32;

    localparam int ID_W   = 4;
    localparam int KIND_W = 3;
    localparam int REQ_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SEND     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RECEIVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WITHDRAW = 2'd2;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        K_GRANTED   = 3'd0,
        K_BUSY      = 3'd1,
        K_PENDED    = 3'd2,
        K_FULL      = 3'd3,
        K_WOKEN     = 3'd4,
        K_DONE      = 3'd5,
        K_WITHDRAWN = 3'd6,
        K_NOT_FOUND = 3'd7
    } kind_t;

endpackage

// ----- rtl/event_flag_group_with_waiters.sv -----
// Event flag group with an ordered table of waiting receivers.
//
// Command channel: a word (req_type, flags, match_all, waiter_id, no_wait)
// is taken at a rising edge where start is high and busy is low. Results
// appear on kind, who, consumed, flags_now and last for exactly one cycle,
// marked by result_valid; last flags the final result of a command. The
// receiver cannot hold results off, and none is ever dropped.
//
// A receive gives its single result in the cycle after acceptance and
// leaves busy low, so commands of this kind may follow back to back.
// A send or a withdraw walks the waiter table, one slot per cycle, out of
// a synchronous RAM with a registered read. Surviving entries are written
// back lower, over the places of removed ones, so the table stays packed
// oldest first. With waiters present, busy is high through the walk and a
// final state, and the final result follows the walk, woken results
// streaming out during it. An empty table leaves busy low and gives its
// single result in the cycle after acceptance.
//
// Reset clears the flag group and the waiter count. The table RAM is not
// cleared: only slots below the count are ever used.
module event_flag_group_with_waiters #(
    parameter int MAX_WAITERS = egw_pkg::DEF_MAX_WAITERS,
    parameter int FLAG_BITS   = egw_pkg::DEF_FLAG_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [egw_pkg::REQ_W-1:0]   req_type,
    input  logic [FLAG_BITS-1:0]        flags,
    input  logic                        match_all,
    input  logic [egw_pkg::ID_W-1:0]    waiter_id,
    input  logic                        no_wait,
    output logic                        result_valid,
    output logic [egw_pkg::KIND_W-1:0]  kind,
    output logic [egw_pkg::ID_W-1:0]    who,
    output logic [FLAG_BITS-1:0]        consumed,
    output logic [FLAG_BITS-1:0]        flags_now,
    output logic                        last
);

    localparam int IW      = $clog2(MAX_WAITERS);
    localparam int CW      = $clog2(MAX_WAITERS + 1);
    localparam int ENTRY_W = egw_pkg::ID_W + FLAG_BITS + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [FLAG_BITS-1:0]        group_reg, group_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [IW-1:0]               proc_idx_reg, proc_idx_next;
    logic [CW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic                        found_reg, found_next;
    logic                        is_send_reg, is_send_next;
    logic [egw_pkg::ID_W-1:0]    id_reg, id_next;

    logic                        valid_reg, valid_next;
    egw_pkg::kind_t              kind_reg, kind_next;
    logic [egw_pkg::ID_W-1:0]    who_reg, who_next;
    logic [FLAG_BITS-1:0]        consumed_reg, consumed_next;
    logic [FLAG_BITS-1:0]        now_reg, now_next;
    logic                        last_reg, last_next;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [IW-1:0]               ram_raddr;
    logic [ENTRY_W-1:0]          ram_wdata;
    logic [ENTRY_W-1:0]          ram_rdata;

    logic [egw_pkg::ID_W-1:0]    rd_owner;
    logic [FLAG_BITS-1:0]        rd_wanted;
    logic                        rd_all;
    logic                        walk_met;
    logic [FLAG_BITS-1:0]        walk_taken;
    logic                        recv_met;
    logic [FLAG_BITS-1:0]        recv_taken;
    logic                        accept;
    logic                        proc_last;
    logic                        remove;

    // Table entry layout: owner in the top bits, wanted set, all-mode in bit 0.
    assign rd_owner  = ram_rdata[ENTRY_W-1 -: egw_pkg::ID_W];
    assign rd_wanted = ram_rdata[FLAG_BITS:1];
    assign rd_all    = ram_rdata[0];

    egw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WAITERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Condition of the slot under inspection against the running group.
    egw_cond #(
        .FLAG_BITS (FLAG_BITS)
    ) u_walk_cond (
        .group    (group_reg),
        .wanted   (rd_wanted),
        .all_mode (rd_all),
        .met      (walk_met),
        .taken    (walk_taken)
    );

    // Condition of an incoming receive.
    egw_cond #(
        .FLAG_BITS (FLAG_BITS)
    ) u_recv_cond (
        .group    (group_reg),
        .wanted   (flags),
        .all_mode (match_all),
        .met      (recv_met),
        .taken    (recv_taken)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign proc_last = ((CW'(proc_idx_reg) + CW'(1)) == count_reg);

    // A send drops every waiter whose condition holds; a withdraw drops only
    // the oldest entry carrying the requested id.
    assign remove = is_send_reg ? walk_met
                                : (!found_reg && (rd_owner == id_reg));

    always_comb
    begin
        state_next    = state_reg;
        group_next    = group_reg;
        count_next    = count_reg;
        proc_idx_next = proc_idx_reg;
        wr_ptr_next   = wr_ptr_reg;
        found_next    = found_reg;
        is_send_next  = is_send_reg;
        id_next       = id_reg;

        valid_next    = 1'b0;
        kind_next     = kind_reg;
        who_next      = who_reg;
        consumed_next = consumed_reg;
        now_next      = now_reg;
        last_next     = last_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = proc_idx_reg + IW'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                // Slot 0 is fetched ahead so a walk can start next cycle.
                ram_raddr = '0;
                if (accept)
                begin
                    id_next       = waiter_id;
                    proc_idx_next = '0;
                    wr_ptr_next   = '0;
                    found_next    = 1'b0;
                    unique case (req_type)
                        egw_pkg::REQ_SEND:
                        begin
                            is_send_next = 1'b1;
                            group_next   = group_reg | flags;
                            if (count_reg == '0)
                            begin
                                valid_next    = 1'b1;
                                kind_next     = egw_pkg::K_DONE;
                                who_next      = '0;
                                consumed_next = '0;
                                now_next      = group_reg | flags;
                                last_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        egw_pkg::REQ_RECEIVE:
                        begin
                            valid_next    = 1'b1;
                            who_next      = waiter_id;
                            consumed_next = '0;
                            now_next      = group_reg;
                            last_next     = 1'b1;
                            if (recv_met)
                            begin
                                kind_next     = egw_pkg::K_GRANTED;
                                consumed_next = recv_taken;
                                group_next    = group_reg & ~flags;
                                now_next      = group_reg & ~flags;
                            end
                            else if (no_wait)
                            begin
                                kind_next = egw_pkg::K_BUSY;
                            end
                            else if (count_reg >= CW'(MAX_WAITERS))
                            begin
                                kind_next = egw_pkg::K_FULL;
                            end
                            else
                            begin
                                kind_next  = egw_pkg::K_PENDED;
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IW-1:0];
                                ram_wdata  = {waiter_id, flags, match_all};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        egw_pkg::REQ_WITHDRAW:
                        begin
                            is_send_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                valid_next    = 1'b1;
                                kind_next     = egw_pkg::K_NOT_FOUND;
                                who_next      = waiter_id;
                                consumed_next = '0;
                                now_next      = group_reg;
                                last_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            // Unused request code: dropped without a result.
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                proc_idx_next = proc_idx_reg + IW'(1);
                if (remove)
                begin
                    if (is_send_reg)
                    begin
                        valid_next    = 1'b1;
                        kind_next     = egw_pkg::K_WOKEN;
                        who_next      = rd_owner;
                        consumed_next = walk_taken;
                        now_next      = group_reg & ~rd_wanted;
                        last_next     = 1'b0;
                        group_next    = group_reg & ~rd_wanted;
                    end
                    else
                    begin
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    // Kept entries move down over the gap left by removals.
                    ram_we      = 1'b1;
                    ram_waddr   = wr_ptr_reg[IW-1:0];
                    ram_wdata   = ram_rdata;
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                end
                if (proc_last)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                count_next    = wr_ptr_reg;
                valid_next    = 1'b1;
                consumed_next = '0;
                now_next      = group_reg;
                last_next     = 1'b1;
                if (is_send_reg)
                begin
                    kind_next = egw_pkg::K_DONE;
                    who_next  = '0;
                end
                else
                begin
                    kind_next = found_reg ? egw_pkg::K_WITHDRAWN : egw_pkg::K_NOT_FOUND;
                    who_next  = id_reg;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            group_reg <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            group_reg <= group_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        wr_ptr_reg   <= wr_ptr_next;
        found_reg    <= found_next;
        is_send_reg  <= is_send_next;
        id_reg       <= id_next;
        kind_reg     <= kind_next;
        who_reg      <= who_next;
        consumed_reg <= consumed_next;
        now_reg      <= now_next;
        last_reg     <= last_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign who          = who_reg;
    assign consumed     = consumed_reg;
    assign flags_now    = now_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // The waiter count never exceeds the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAITERS))
    else $error("waiter count beyond table depth");

    // Compaction writes never run ahead of the slot being inspected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (wr_ptr_reg <= CW'(proc_idx_reg)))
    else $error("compaction write pointer ahead of read");

    // Every walk ends in exactly one final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |=> (valid_reg && last_reg && !busy))
    else $error("walk did not end with a final result");

    // Woken results inside a walk are never marked final.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_WALK) && valid_reg |-> !last_reg)
    else $error("final mark on a woken result");
`endif

endmodule

// ----- rtl/egw_ram.sv -----
module egw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/egw_cond.sv -----
module egw_cond #(
    parameter int FLAG_BITS = egw_pkg::DEF_FLAG_BITS
) (
    input  logic [FLAG_BITS-1:0] group,
    input  logic [FLAG_BITS-1:0] wanted,
    input  logic                 all_mode,
    output logic                 met,
    output logic [FLAG_BITS-1:0] taken
);

    // All-mode needs every wanted bit present; any-mode needs at least one.
    assign taken = group & wanted;
    assign met   = all_mode ? (taken == wanted) : (taken != '0);

endmodule
